>>> rtl/pli_pkg.sv
package pli_pkg;

   localparam int MAX_POINTS_DEFAULT = 64;
   localparam int QUEUE_DEPTH = 2;
   localparam int DIV_WIDTH = 33;

   localparam logic [6:0] POINT_COUNT_RESET = 7'd2;
   localparam logic [6:0] POINT_COUNT_MIN = 7'd2;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EVAL = 1'b1;

   localparam logic [1:0] STATUS_LOADED = 2'd0;
   localparam logic [1:0] STATUS_INTERP = 2'd1;
   localparam logic [1:0] STATUS_OUT_OF_RANGE = 2'd2;
   localparam logic [1:0] STATUS_DEGENERATE = 2'd3;

   typedef struct packed {
      logic              opcode;
      logic [5:0]        point_index;
      logic signed [31:0] x_value;
      logic signed [31:0] y_value;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] y_result;
      logic [1:0]         status;
   } rsp_word_type;

   // Command kinds decided by the front end.
   typedef enum logic [1:0] {
      KIND_LOAD,
      KIND_SKIP,
      KIND_EVAL,
      KIND_EMPTY
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type       kind;
      logic signed [31:0] x_value;
      logic signed [31:0] y_value;
   } cmd_type;

endpackage

>>> rtl/pli_front.sv
module pli_front import pli_pkg::*; #(
   parameter int MAX_POINTS = MAX_POINTS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  req_word_type                  req_word,
   input  logic                          csr_wr_en,
   input  logic [6:0]                    csr_wr_data,
   output logic                          q_valid,
   output cmd_type                       q_cmd,
   output logic [$clog2(MAX_POINTS)-1:0] q_slot,
   input  logic                          q_pop
);

   localparam int AW = $clog2(MAX_POINTS);
   localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);

   logic [6:0]     point_count_ff;
   logic [QPW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0] count_ff, count_in;
   cmd_type        cmd_q_ff [QUEUE_DEPTH];
   logic [AW-1:0]  slot_q_ff [QUEUE_DEPTH];
   cmd_type        new_cmd;
   logic [AW-1:0]  new_slot;
   logic           push;

   assign req_stall = (count_ff == QCW'(QUEUE_DEPTH));
   assign push = req_valid && !req_stall;
   assign q_valid = (count_ff != '0);
   assign q_cmd = cmd_q_ff[rd_ptr_ff];
   assign q_slot = slot_q_ff[rd_ptr_ff];

   // The slot field carries the write slot for a load and the last
   // breakpoint index for an evaluate.
   always_comb begin
      new_cmd.x_value = req_word.x_value;
      new_cmd.y_value = req_word.y_value;
      new_slot = AW'(req_word.point_index);
      if (req_word.opcode == OP_LOAD) begin
         if (32'(req_word.point_index) < 32'(MAX_POINTS)) begin
            new_cmd.kind = KIND_LOAD;
         end else begin
            new_cmd.kind = KIND_SKIP;
         end
      end else begin
         if (point_count_ff < POINT_COUNT_MIN) begin
            new_cmd.kind = KIND_EMPTY;
         end else begin
            new_cmd.kind = KIND_EVAL;
         end
         if (32'(point_count_ff) > 32'(MAX_POINTS)) begin
            new_slot = AW'(MAX_POINTS - 1);
         end else begin
            new_slot = AW'(point_count_ff - 7'd1);
         end
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= POINT_COUNT_RESET;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            point_count_ff <= csr_wr_data;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         cmd_q_ff[wr_ptr_ff] <= new_cmd;
         slot_q_ff[wr_ptr_ff] <= new_slot;
      end
   end

endmodule

>>> rtl/pli_div.sv
module pli_div import pli_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_WIDTH-1:0] num_d,
   input  logic [DIV_WIDTH-1:0] mul_a,
   input  logic [DIV_WIDTH-1:0] den_w,
   output logic                 done,
   output logic [DIV_WIDTH-1:0] quot
);

   localparam int CW = $clog2(DIV_WIDTH);
   localparam int TW = DIV_WIDTH + 2;

   logic                 busy_ff;
   logic                 done_ff;
   logic [CW-1:0]        cnt_ff;
   logic [DIV_WIDTH-1:0] a_ff, d_ff, w_ff, r_ff, q_ff;
   logic [TW-1:0]        t_sum, w1, w2;
   logic [DIV_WIDTH-1:0] r_in, q_in;

   // Computes floor(d * a / w) one multiplier bit per cycle, MSB first.
   // The remainder stays below w, so at most two subtractions fit a step.
   always_comb begin
      w1 = {2'b00, w_ff};
      w2 = {1'b0, w_ff, 1'b0};
      t_sum = {1'b0, r_ff, 1'b0} + (a_ff[DIV_WIDTH-1] ? {2'b00, d_ff} : '0);
      if (t_sum >= w2) begin
         r_in = DIV_WIDTH'(t_sum - w2);
         q_in = {q_ff[DIV_WIDTH-2:0], 1'b0} + DIV_WIDTH'(2);
      end else if (t_sum >= w1) begin
         r_in = DIV_WIDTH'(t_sum - w1);
         q_in = {q_ff[DIV_WIDTH-2:0], 1'b1};
      end else begin
         r_in = DIV_WIDTH'(t_sum);
         q_in = {q_ff[DIV_WIDTH-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff <= CW'(DIV_WIDTH - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff <= mul_a;
         d_ff <= num_d;
         w_ff <= den_w;
         r_ff <= '0;
         q_ff <= '0;
      end else if (busy_ff) begin
         a_ff <= {a_ff[DIV_WIDTH-2:0], 1'b0};
         r_ff <= r_in;
         q_ff <= q_in;
      end
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

>>> rtl/pli_back.sv
module pli_back import pli_pkg::*; #(
   parameter int MAX_POINTS = MAX_POINTS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   input  cmd_type                       q_cmd,
   input  logic [$clog2(MAX_POINTS)-1:0] q_slot,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output rsp_word_type                  rsp_word
);

   localparam int AW = $clog2(MAX_POINTS);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DIVIDE,
      S_FINISH
   } state_type;

   state_type            state_ff, state_in;
   logic [AW-1:0]        last_ff, last_in;
   logic signed [31:0]   arg_ff, arg_in;
   logic [AW-1:0]        scan_addr_ff, scan_addr_in;
   logic                 issue_done_ff, issue_done_in;
   logic                 data_vld_ff, data_vld_in;
   logic [AW-1:0]        data_idx_ff, data_idx_in;
   logic signed [31:0]   x0_ff, x0_in;
   logic signed [31:0]   y0_ff, y0_in;
   logic [DIV_WIDTH-1:0] div_d_ff, div_d_in;
   logic [DIV_WIDTH-1:0] div_a_ff, div_a_in;
   logic [DIV_WIDTH-1:0] div_w_ff, div_w_in;
   logic                 neg_ff, neg_in;
   logic                 div_start_ff, div_start_in;
   rsp_word_type         res_ff, res_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_word_type         rsp_word_ff, rsp_word_in;

   logic [31:0]          x_mem [MAX_POINTS];
   logic [31:0]          y_mem [MAX_POINTS];
   logic [31:0]          x_rd_ff, y_rd_ff;
   logic                 mem_we;

   logic signed [31:0]   cur_x, cur_y;
   logic signed [32:0]   width_s, dist_s, dy_s;
   logic [DIV_WIDTH-1:0] dy_mag;
   logic                 hit;
   logic                 div_done;
   logic [DIV_WIDTH-1:0] div_quot;
   logic signed [34:0]   sum_s;
   logic signed [31:0]   sat_y;

   assign cur_x = signed'(x_rd_ff);
   assign cur_y = signed'(y_rd_ff);
   assign width_s = 33'(cur_x) - 33'(x0_ff);
   assign dist_s = 33'(arg_ff) - 33'(x0_ff);
   assign dy_s = 33'(cur_y) - 33'(y0_ff);
   assign dy_mag = dy_s[32] ? DIV_WIDTH'(-dy_s) : DIV_WIDTH'(dy_s);
   assign hit = (arg_ff >= x0_ff) && (arg_ff <= cur_x);

   always_comb begin
      if (neg_ff) begin
         sum_s = 35'(y0_ff) - signed'({2'b00, div_quot});
      end else begin
         sum_s = 35'(y0_ff) + signed'({2'b00, div_quot});
      end
      if (sum_s > 35'sh0_7FFF_FFFF) begin
         sat_y = 32'sh7FFF_FFFF;
      end else if (sum_s < -35'sh0_8000_0000) begin
         sat_y = -32'sh8000_0000;
      end else begin
         sat_y = 32'(sum_s);
      end
   end

   always_comb begin
      state_in = state_ff;
      last_in = last_ff;
      arg_in = arg_ff;
      scan_addr_in = scan_addr_ff;
      issue_done_in = issue_done_ff;
      data_vld_in = 1'b0;
      data_idx_in = scan_addr_ff;
      x0_in = x0_ff;
      y0_in = y0_ff;
      div_d_in = div_d_ff;
      div_a_in = div_a_ff;
      div_w_in = div_w_ff;
      neg_in = neg_ff;
      div_start_in = 1'b0;
      res_in = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in = rsp_word_ff;
      q_pop = 1'b0;
      mem_we = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               last_in = q_slot;
               arg_in = q_cmd.x_value;
               res_in.y_result = '0;
               case (q_cmd.kind)
                  KIND_LOAD: begin
                     mem_we = 1'b1;
                     res_in.status = STATUS_LOADED;
                     state_in = S_FINISH;
                  end
                  KIND_EMPTY: begin
                     res_in.status = STATUS_OUT_OF_RANGE;
                     state_in = S_FINISH;
                  end
                  KIND_EVAL: begin
                     scan_addr_in = '0;
                     issue_done_in = 1'b0;
                     state_in = S_SCAN;
                  end
                  default: begin
                     res_in.status = STATUS_LOADED;
                     state_in = S_FINISH;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (!issue_done_ff) begin
               data_vld_in = 1'b1;
               if (scan_addr_ff == last_ff) begin
                  issue_done_in = 1'b1;
               end else begin
                  scan_addr_in = scan_addr_ff + 1'b1;
               end
            end
            if (data_vld_ff) begin
               if (data_idx_ff == '0) begin
                  x0_in = cur_x;
                  y0_in = cur_y;
               end else if (hit) begin
                  if (width_s == '0) begin
                     res_in.y_result = y0_ff;
                     res_in.status = STATUS_DEGENERATE;
                     state_in = S_FINISH;
                  end else begin
                     div_d_in = DIV_WIDTH'(dist_s);
                     div_a_in = dy_mag;
                     div_w_in = DIV_WIDTH'(width_s);
                     neg_in = dy_s[32];
                     div_start_in = 1'b1;
                     state_in = S_DIVIDE;
                  end
               end else begin
                  x0_in = cur_x;
                  y0_in = cur_y;
                  if (data_idx_ff == last_ff) begin
                     res_in.y_result = '0;
                     res_in.status = STATUS_OUT_OF_RANGE;
                     state_in = S_FINISH;
                  end
               end
            end
         end
         S_DIVIDE: begin
            if (div_done) begin
               res_in.y_result = sat_y;
               res_in.status = STATUS_INTERP;
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_word_in = res_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         issue_done_ff <= 1'b0;
         data_vld_ff <= 1'b0;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         issue_done_ff <= issue_done_in;
         data_vld_ff <= data_vld_in;
         div_start_ff <= div_start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      last_ff <= last_in;
      arg_ff <= arg_in;
      scan_addr_ff <= scan_addr_in;
      data_idx_ff <= data_idx_in;
      x0_ff <= x0_in;
      y0_ff <= y0_in;
      div_d_ff <= div_d_in;
      div_a_ff <= div_a_in;
      div_w_ff <= div_w_in;
      neg_ff <= neg_in;
      res_ff <= res_in;
      rsp_word_ff <= rsp_word_in;
   end

   // Breakpoint table: one write port for loads, one read port for the scan.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         x_mem[q_slot] <= q_cmd.x_value;
         y_mem[q_slot] <= q_cmd.y_value;
      end
      x_rd_ff <= x_mem[scan_addr_ff];
      y_rd_ff <= y_mem[scan_addr_ff];
   end

   pli_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start_ff),
      .num_d (div_d_ff),
      .mul_a (div_a_ff),
      .den_w (div_w_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word = rsp_word_ff;

endmodule

>>> rtl/piecewise_linear_interpolator_unit.sv
// A load is written to the table and answered; an evaluate scans the table until an interval
// brackets the argument or the last breakpoint in use is passed, and may then run the divider.
// The back end takes one item at a time; its pace is set by the one-entry-per-cycle table
// read port and the one-bit-per-cycle divider.
// Reset (synchronous, active high) clears the control state and sets point_count to 2;
// the breakpoint table is not cleared and holds nothing meaningful until written.
module piecewise_linear_interpolator_unit import pli_pkg::*; #(
   parameter int MAX_POINTS = MAX_POINTS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word,
   input  logic         csr_wr_en,
   input  logic [6:0]   csr_wr_data
);

   localparam int AW = $clog2(MAX_POINTS);

   // The front end decodes each request word into a command and parks it
   // in a short queue. It also owns the point_count register, so an
   // evaluate carries the index of the last breakpoint it has to look at.
   // Loads aimed past the end of the table are turned into no-op loads.
   logic          q_valid;
   cmd_type       q_cmd;
   logic [AW-1:0] q_slot;
   logic          q_pop;

   pli_front #(
      .MAX_POINTS (MAX_POINTS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_valid     (q_valid),
      .q_cmd       (q_cmd),
      .q_slot      (q_slot),
      .q_pop       (q_pop)
   );

   // The back end holds the breakpoint table. It writes loads directly,
   // and for an evaluate it streams the table one entry per cycle, keeping
   // the previous entry, until the first interval that brackets the
   // argument. A zero-width interval returns its left ordinate; otherwise
   // the bit-serial divider forms the scaled offset, which is added
   // to the left ordinate and saturated. Results leave through an output
   // register, so the queue keeps filling while a result waits.
   pli_back #(
      .MAX_POINTS (MAX_POINTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_cmd     (q_cmd),
      .q_slot    (q_slot),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule
